### rtl/ita_pkg.sv
// Shared types, constants and character helpers for the integer to ASCII formatter.
package ita_pkg;

	localparam int unsigned VALUE_W       = 64;
	localparam int unsigned OP_W          = 3;
	localparam int unsigned WIDTH_W       = 6;
	localparam int unsigned CHAR_W        = 8;
	localparam int unsigned DEC_BITS      = 32;
	localparam int unsigned DEC_DIGITS    = 10;
	localparam int unsigned HEX_DIGITS    = 16;
	localparam int unsigned CNT_W         = 5;
	localparam int unsigned STEP_W        = 5;
	localparam int unsigned MAX_WIDTH_DEF = 48;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef enum logic [OP_W-1:0] {
		OP_SDEC = 3'd0,
		OP_UDEC = 3'd1,
		OP_HEXL = 3'd2,
		OP_HEXU = 3'd3,
		OP_PTR  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_NORM,
		S_ZERO,
		S_X,
		S_SIGN,
		S_PAD,
		S_DIGIT
	} state_t;

	// ASCII for one digit value, upper or lower case letters
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10)
			c = CH_ZERO + {4'd0, d};
		else if (upper)
			c = 8'h41 + {4'd0, d - 4'd10};
		else
			c = 8'h61 + {4'd0, d - 4'd10};
		return c;
	endfunction

endpackage

### rtl/ita_if.sv
// Valid/ready channel interfaces for the number input and the character output.
interface ita_num_if import ita_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [VALUE_W-1:0]   value;
	logic [OP_W-1:0]      operation;
	logic [WIDTH_W-1:0]   min_width;

	modport source(output valid, value, operation, min_width, input ready);
	modport sink(input valid, value, operation, min_width, output ready);
endinterface

interface ita_char_if import ita_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CHAR_W-1:0]    out_char;
	logic                 last;

	modport source(output valid, out_char, last, input ready);
	modport sink(input valid, out_char, last, output ready);
endinterface

### rtl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: bit-serial binary to decimal/hex text, one character per beat.
//
//  channel  modport  payload                          beat
//  num      sink     value, operation, min_width      one number to format
//  chars    source   out_char, last                   one ASCII character
//
// Decimal kinds run shift-and-add-3 over the 32-bit value (one input bit per cycle),
// hex kinds skip that; then leading zero digits are dropped one at a time until
// the top digit is found, then the characters go out one per beat (up to 2 + MAX_WIDTH).
// arst_n clears the sequencer and the output register's valid.
// A stalled chars beat holds the sequencer in its output states; num is taken only in idle.
module integer_to_ascii_formatter import ita_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ita_num_if.sink    num,
	ita_char_if.source chars
);

	localparam logic [WIDTH_W-1:0] WMAX = WIDTH_W'(MAX_WIDTH);

	state_t                 state_q, state_d;
	logic [DEC_BITS-1:0]    bin_q;
	logic [VALUE_W-1:0]     dig_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [STEP_W-1:0]      step_q;
	logic [WIDTH_W-1:0]     width_q;
	logic [WIDTH_W-1:0]     pad_q;
	logic                   neg_q;
	logic                   upper_q;
	logic                   ptr_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic                   out_last_q;

	op_t                    op_in;
	logic                   accept;
	logic                   slot_free;
	logic [3:0]             top_idx;
	logic [3:0]             top_nib;
	logic                   norm_done;
	logic [WIDTH_W-1:0]     body;
	logic [WIDTH_W-1:0]     pad_n;
	logic [DEC_DIGITS*4-1:0] bcd_adj;
	logic [DEC_BITS-1:0]    mag;

	logic                   num_ready;
	logic                   emit;
	logic [CHAR_W-1:0]      char_d;
	logic                   last_d;

	assign op_in     = op_t'(num.operation);
	assign accept    = num.valid && num_ready;
	assign slot_free = !out_valid_q || chars.ready;

	assign top_idx   = 4'(cnt_q - CNT_W'(1));
	assign top_nib   = dig_q[{top_idx, 2'b00} +: 4];
	assign norm_done = (cnt_q == CNT_W'(1)) || (top_nib != 4'd0);

	assign body  = WIDTH_W'(cnt_q) + WIDTH_W'(neg_q);
	assign pad_n = (width_q > body) ? width_q - body : '0;

	// magnitude of the signed 32-bit reading
	assign mag = num.value[DEC_BITS-1] ? DEC_BITS'(0) - num.value[DEC_BITS-1:0]
		: num.value[DEC_BITS-1:0];

	// add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (dig_q[i*4 +: 4] >= 4'd5)
				bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
			else
				bcd_adj[i*4 +: 4] = dig_q[i*4 +: 4];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (num.valid) begin
					case (op_in) inside
						OP_SDEC, OP_UDEC:        state_d = S_CONV;
						OP_HEXL, OP_HEXU, OP_PTR: state_d = S_NORM;
						default:                 state_d = S_IDLE;
					endcase
				end
			end
			S_CONV: begin
				if (step_q == '0)
					state_d = S_NORM;
			end
			S_NORM: begin
				if (norm_done) begin
					if (ptr_q)
						state_d = S_ZERO;
					else if (neg_q)
						state_d = S_SIGN;
					else if (pad_n != '0)
						state_d = S_PAD;
					else
						state_d = S_DIGIT;
				end
			end
			S_ZERO: begin
				if (slot_free)
					state_d = S_X;
			end
			S_X, S_SIGN: begin
				if (slot_free)
					state_d = (pad_q != '0) ? S_PAD : S_DIGIT;
			end
			S_PAD: begin
				if (slot_free && pad_q == WIDTH_W'(1))
					state_d = S_DIGIT;
			end
			S_DIGIT: begin
				if (slot_free && cnt_q == CNT_W'(1))
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		num_ready = 1'b0;
		emit      = 1'b0;
		char_d    = CH_ZERO;
		last_d    = 1'b0;
		unique case (state_q)
			S_IDLE: num_ready = 1'b1;
			S_ZERO, S_PAD: begin
				emit   = slot_free;
				char_d = CH_ZERO;
			end
			S_X: begin
				emit   = slot_free;
				char_d = CH_X;
			end
			S_SIGN: begin
				emit   = slot_free;
				char_d = CH_MINUS;
			end
			S_DIGIT: begin
				emit   = slot_free;
				char_d = digit_char(top_nib, upper_q);
				last_d = (cnt_q == CNT_W'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			step_q <= '0;
			pad_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q  <= (op_in == OP_SDEC || op_in == OP_UDEC)
							? CNT_W'(DEC_DIGITS) : CNT_W'(HEX_DIGITS);
						step_q <= STEP_W'(DEC_BITS - 1);
					end
				end
				S_CONV: step_q <= step_q - STEP_W'(1);
				S_NORM: begin
					if (norm_done)
						pad_q <= pad_n;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				S_PAD: begin
					if (slot_free)
						pad_q <= pad_q - WIDTH_W'(1);
				end
				S_DIGIT: begin
					if (slot_free)
						cnt_q <= cnt_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath: digit shift registers and item flags
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			neg_q   <= (op_in == OP_SDEC) && num.value[DEC_BITS-1];
			upper_q <= (op_in == OP_HEXU);
			ptr_q   <= (op_in == OP_PTR);
			width_q <= (num.min_width > WMAX) ? WMAX : num.min_width;
			bin_q   <= (op_in == OP_SDEC) ? mag : num.value[DEC_BITS-1:0];
			dig_q   <= (op_in == OP_SDEC || op_in == OP_UDEC) ? '0 : num.value;
		end else if (state_q == S_CONV) begin
			dig_q[DEC_DIGITS*4-1:0] <= {bcd_adj[DEC_DIGITS*4-2:0], bin_q[DEC_BITS-1]};
			bin_q                   <= {bin_q[DEC_BITS-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (chars.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= char_d;
			out_last_q <= last_d;
		end
	end

	assign num.ready      = num_ready;
	assign chars.valid    = out_valid_q;
	assign chars.out_char = out_char_q;
	assign chars.last     = out_last_q;

	// a stalled beat keeps its character until taken
	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !chars.ready |=>
			out_valid_q && $stable(out_char_q) && $stable(out_last_q))
		else $error("pending beat changed before it was taken");

	// a valid kind always starts work
	ast_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op_in == OP_SDEC || op_in == OP_UDEC || op_in == OP_HEXL ||
			op_in == OP_HEXU || op_in == OP_PTR) |=> state_q != S_IDLE)
		else $error("accepted number did not start");

	// digit count stays in range while digits are in use
	ast_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM || state_q == S_DIGIT) |->
			cnt_q != '0 && cnt_q <= CNT_W'(HEX_DIGITS))
		else $error("digit count out of range");

	ast_pad: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PAD |-> pad_q != '0)
		else $error("padding with empty pad count");

endmodule
